// ===== hdl/kdb_pkg.sv =====
// Shared types and phase codes for the keypad debouncer.
// Used by kdb_cfg, kdb_state and keypad_debounce_fsm_top.
`timescale 1ns / 1ps

package kdb_pkg;

    localparam int KEY_W   = 4;
    localparam int TICKS_W = 8;
    localparam int MASK_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 2'd1;

    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_BOUNCING = 2'd1;
    localparam logic [1:0] PH_PRESSED  = 2'd2;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd4;

    typedef struct packed {
        logic [TICKS_W-1:0] debounce_ticks;
        logic [MASK_W-1:0]  active_low_mask;
    } kdb_cfg_t;

    typedef struct packed {
        logic [1:0]       key_phase;
        logic             key_pressed;
        logic [KEY_W-1:0] key_number;
    } kdb_result_t;

endpackage

// ===== hdl/keypad_debounce_fsm_top.sv =====
// Keypad debouncer: input and result registers around the per-key store.
// Depends on kdb_pkg, kdb_cfg and kdb_state.
`timescale 1ns / 1ps

// Each request carries one sample of one key and yields exactly one result,
// in order. A sample sits in the input register, where the key's stored
// phase and run counters are read, updated and written back, and the
// result is loaded into the output register; throughput is one request
// per cycle while m_tready is high. Samples of the same key may follow
// each other directly. Configuration writes are expected only while no
// request is in flight.
module keypad_debounce_fsm_top #(
    parameter int NUM_KEYS    = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // key_index[3:0], raw_level[4]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // key_number[3:0], key_pressed[4],
                                                       // key_phase[6:5]
    input  logic                             cfg_wr_en,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import kdb_pkg::*;

    kdb_cfg_t    cfg;
    kdb_result_t result;

    logic             in_valid_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic             in_lvl_reg;
    logic             out_valid_reg;
    kdb_result_t      out_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg <= s_tdata[KEY_W-1:0];
            in_lvl_reg <= s_tdata[KEY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance)
            out_reg <= result;
    end

    kdb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kdb_state #(
        .NUM_KEYS    (NUM_KEYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (advance),
        .key       (in_key_reg),
        .raw_level (in_lvl_reg),
        .cfg       (cfg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    a_adv_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result register not loaded after request advanced");

    a_held_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_key_reg)
                                     && $stable(in_lvl_reg))
        else $error("stalled input request lost or changed");

    a_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ({3'b000, m_tdata[3:0]} >= 7'(NUM_KEYS))
            |-> m_tdata[6:4] == 3'b000)
        else $error("out-of-range key reported non-zero state");

endmodule

// ===== hdl/kdb_cfg.sv =====
// Configuration register file for the keypad debouncer.
// Depends on kdb_pkg.
`timescale 1ns / 1ps

module kdb_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output kdb_pkg::kdb_cfg_t                cfg
);
    import kdb_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    logic [MASK_W-1:0]  mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
            mask_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:  ticks_reg <= cfg_wdata[TICKS_W-1:0];
                REG_ACTIVE_LOW_MASK: mask_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.debounce_ticks  = ticks_reg;
    assign cfg.active_low_mask = mask_reg;

endmodule

// ===== hdl/kdb_state.sv =====
// Per-key debounce store and its read-modify-write update.
// Depends on kdb_pkg.
`timescale 1ns / 1ps

module kdb_state #(
    parameter int NUM_KEYS    = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        upd_en,
    input  logic [kdb_pkg::KEY_W-1:0]   key,
    input  logic                        raw_level,
    input  kdb_pkg::kdb_cfg_t           cfg,
    output kdb_pkg::kdb_result_t        result
);
    import kdb_pkg::*;

    localparam int IW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int XW  = 7;
    localparam int TW  = 17;
    localparam logic [TW-1:0] CMAX = TW'((1 << COUNT_WIDTH) - 1);

    logic [1:0]             phase_reg [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] high_reg  [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] low_reg   [NUM_KEYS];
    logic                   rep_reg   [NUM_KEYS];

    logic [XW-1:0]          key_ext;
    logic                   in_range;
    logic [IW-1:0]          idx;
    logic                   lvl;
    logic [TW-1:0]          ticks_ext;
    logic [TW-1:0]          t_eff;
    logic [1:0]             ph_cur;
    logic [1:0]             ph_next;
    logic [COUNT_WIDTH-1:0] high_cur;
    logic [COUNT_WIDTH-1:0] low_cur;
    logic [COUNT_WIDTH-1:0] high_next;
    logic [COUNT_WIDTH-1:0] low_next;
    logic                   rep_next;

    assign key_ext  = {{(XW-KEY_W){1'b0}}, key};
    assign in_range = key_ext < XW'(NUM_KEYS);
    assign idx      = key_ext[IW-1:0];
    assign lvl      = raw_level ^ cfg.active_low_mask[key];

    assign ticks_ext = {{(TW-TICKS_W){1'b0}}, cfg.debounce_ticks};
    always_comb begin
        if (ticks_ext == '0)
            t_eff = TW'(1);
        else if (ticks_ext > CMAX)
            t_eff = CMAX;
        else
            t_eff = ticks_ext;
    end

    assign ph_cur   = phase_reg[idx];
    assign high_cur = high_reg[idx];
    assign low_cur  = low_reg[idx];

    always_comb begin
        ph_next   = ph_cur;
        high_next = high_cur;
        low_next  = low_cur;
        rep_next  = rep_reg[idx];
        unique case (ph_cur)
            PH_BOUNCING: begin
                if (lvl) begin
                    low_next  = '0;
                    high_next = (TW'(high_cur) == CMAX) ? high_cur
                                                        : high_cur + 1'b1;
                    if (TW'(high_next) >= t_eff)
                        ph_next = PH_PRESSED;
                end else begin
                    high_next = '0;
                    low_next  = (TW'(low_cur) == CMAX) ? low_cur
                                                       : low_cur + 1'b1;
                    if (TW'(low_next) >= t_eff)
                        ph_next = PH_RELEASED;
                end
            end
            PH_PRESSED: begin
                if (lvl) begin
                    rep_next = 1'b1;
                end else begin
                    ph_next   = PH_BOUNCING;
                    high_next = '0;
                    low_next  = '0;
                end
            end
            default: begin
                if (lvl) begin
                    ph_next   = PH_BOUNCING;
                    high_next = '0;
                    low_next  = '0;
                end else begin
                    ph_next  = PH_RELEASED;
                    rep_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                phase_reg[k] <= PH_RELEASED;
                high_reg[k]  <= '0;
                low_reg[k]   <= '0;
                rep_reg[k]   <= 1'b0;
            end
        end else if (upd_en && in_range) begin
            phase_reg[idx] <= ph_next;
            high_reg[idx]  <= high_next;
            low_reg[idx]   <= low_next;
            rep_reg[idx]   <= rep_next;
        end
    end

    assign result.key_number  = key;
    assign result.key_pressed = in_range ? rep_next : 1'b0;
    assign result.key_phase   = in_range ? ph_next : PH_RELEASED;

endmodule

// ===== sim/kdb_checker.sv =====
// Checker for the keypad debouncer: watches the request, result and register
// ports, predicts every debounce report and compares it with the block's output.
// Depends on kdb_pkg for the phase codes, register indexes and result layout.
`timescale 1ns / 1ps

module kdb_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // key_index[3:0], raw_level[4]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,   // key_number[3:0], key_pressed[4],
                                                      // key_phase[6:5]
    input  logic                           cfg_wr_en,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             outstanding
);
    import kdb_pkg::*;

    logic [TICKS_W-1:0] tick_setting;
    logic [MASK_W-1:0]  polarity_mask;

    logic [1:0] phase_mem  [16];
    logic [7:0] high_runs  [16];
    logic [7:0] low_runs   [16];
    logic       held_state [16];

    kdb_result_t report_q [$];

    function automatic logic [7:0] run_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    task automatic predict_report(input logic [3:0] key, input logic raw);
        logic        lvl;
        logic [1:0]  ph;
        logic [7:0]  t;
        kdb_result_t r;
        lvl = raw ^ polarity_mask[key];
        t   = (tick_setting == 8'd0) ? 8'd1 : tick_setting;
        ph  = phase_mem[key];
        case (ph)
            PH_BOUNCING: begin
                if (lvl) begin
                    low_runs[key]  = 8'd0;
                    high_runs[key] = run_inc(high_runs[key]);
                    if (high_runs[key] >= t) ph = PH_PRESSED;
                end else begin
                    high_runs[key] = 8'd0;
                    low_runs[key]  = run_inc(low_runs[key]);
                    if (low_runs[key] >= t) ph = PH_RELEASED;
                end
            end
            PH_PRESSED: begin
                if (lvl) begin
                    held_state[key] = 1'b1;
                end else begin
                    ph             = PH_BOUNCING;
                    high_runs[key] = 8'd0;
                    low_runs[key]  = 8'd0;
                end
            end
            default: begin
                if (lvl) begin
                    ph             = PH_BOUNCING;
                    high_runs[key] = 8'd0;
                    low_runs[key]  = 8'd0;
                end else begin
                    ph              = PH_RELEASED;
                    held_state[key] = 1'b0;
                end
            end
        endcase
        phase_mem[key] = ph;
        r.key_number  = key;
        r.key_pressed = held_state[key];
        r.key_phase   = ph;
        report_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        kdb_result_t want;
        kdb_result_t got;
        if (!aresetn) begin
            errors        = 0;
            tick_setting  = TICKS_RESET;
            polarity_mask = '0;
            for (int k = 0; k < 16; k++) begin
                phase_mem[k]  = PH_RELEASED;
                high_runs[k]  = 8'd0;
                low_runs[k]   = 8'd0;
                held_state[k] = 1'b0;
            end
            report_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS:  tick_setting  = cfg_wdata[TICKS_W-1:0];
                    REG_ACTIVE_LOW_MASK: polarity_mask = cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = kdb_result_t'(m_tdata[6:0]);
                if (report_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = report_q.pop_front();
                    if (got.key_number !== want.key_number) begin
                        errors++;
                        $display("%0t: key_number expected %0d actual %0d",
                                 $time, want.key_number, got.key_number);
                    end
                    if (got.key_pressed !== want.key_pressed) begin
                        errors++;
                        $display("%0t: key_pressed expected %0d actual %0d (key %0d)",
                                 $time, want.key_pressed, got.key_pressed, want.key_number);
                    end
                    if (got.key_phase !== want.key_phase) begin
                        errors++;
                        $display("%0t: key_phase expected %0d actual %0d (key %0d)",
                                 $time, want.key_phase, got.key_phase, want.key_number);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_report(s_tdata[3:0], s_tdata[4]);
        end
        outstanding = report_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the keypad debouncer testbench: clock, reset, key sample stimulus and
// register settings; the verdict comes from kdb_checker's error count.
// Depends on kdb_pkg, kdb_checker and keypad_debounce_fsm_top.
`timescale 1ns / 1ps

module testbench;
    import kdb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int errors;
    int outstanding;
    int cycle_count = 0;
    bit idle_on     = 1'b1;

    keypad_debounce_fsm_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    kdb_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= !(idle_on && $urandom_range(99) < 15);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(input logic [3:0] key, input logic raw);
        while (idle_on && $urandom_range(99) < 15) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, raw, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [7:0] ticks, input logic [15:0] mask);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_index = REG_DEBOUNCE_TICKS;
        cfg_wdata = {8'h00, ticks};
        @(negedge aclk);
        cfg_index = REG_ACTIVE_LOW_MASK;
        cfg_wdata = mask;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // bouncing prefix then a steady run of t to t+3 samples, other keys mixed in
    task automatic key_burst(input int t, input logic [15:0] mask, inout int sent);
        logic [3:0] k;
        logic       target;
        int         n_noise;
        int         n_run;
        k       = 4'($urandom_range(15));
        target  = 1'($urandom_range(1));
        n_noise = $urandom_range(0, (t < 8) ? t + 2 : 6);
        n_run   = t + $urandom_range(0, 3);
        for (int i = 0; i < n_noise + n_run; i++) begin
            if ($urandom_range(99) < 25) begin
                send_sample(4'($urandom_range(15)), 1'($urandom_range(1)));
                sent++;
            end
            if (i < n_noise)
                send_sample(k, 1'($urandom_range(1)));
            else
                send_sample(k, target ^ mask[k]);
            sent++;
        end
    endtask

    task automatic random_phase(input logic [7:0] ticks, input logic [15:0] mask,
                                input int budget, input bit pause_mid);
        int  sent;
        int  t;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        t      = (ticks == 8'd0) ? 1 : ticks;
        apply_settings(ticks, mask);
        while (sent < budget) begin
            key_burst(t, mask, sent);
            if (pause_mid && !paused && sent >= budget / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: four ticks, no inversion
        send_sample(4'd15, 1'b0);
        send_sample(4'd0, 1'b1);
        send_sample(4'd0, 1'b0);
        repeat (4) send_sample(4'd0, 1'b1);
        send_sample(4'd0, 1'b1);
        repeat (5) send_sample(4'd0, 1'b0);
        send_sample(4'd0, 1'b0);
        send_sample(4'd15, 1'b1);

        // zero ticks acts as one; unknown register indexes are ignored
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_index = REG_DEBOUNCE_TICKS;
        cfg_wdata = 16'h0000;
        @(negedge aclk);
        cfg_index = REG_ACTIVE_LOW_MASK;
        cfg_wdata = 16'h8001;
        @(negedge aclk);
        cfg_index = 2'd2;
        cfg_wdata = 16'hFFFF;
        @(negedge aclk);
        cfg_index = 2'd3;
        cfg_wdata = 16'hFFFF;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        repeat (3) send_sample(4'd0, 1'b0);
        send_sample(4'd15, 1'b1);
        send_sample(4'd7, 1'b1);

        random_phase(8'd1, 16'hFFFF, 250, 1'b0);
        idle_on = 1'b0;
        random_phase(8'd0, 16'($urandom_range(16'hFFFF)), 250, 1'b0);
        idle_on = 1'b1;
        random_phase(8'd255, 16'h0000, 600, 1'b0);
        random_phase(8'd2, 16'($urandom_range(16'hFFFF)), 250, 1'b1);
        random_phase(8'($urandom_range(3, 7)), 16'($urandom_range(16'hFFFF)), 250, 1'b0);
        random_phase(8'($urandom_range(3, 7)), 16'($urandom_range(16'hFFFF)), 250, 1'b0);
        random_phase(8'd4, 16'h0000, 100, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
